// ===== design/pcmvr_pkg.sv =====
// shared types and constants for the pcm volume ramp block
package pcmvr_pkg;
  localparam int DefMaxFrames = 4096;
  localparam int DefMaxChannels = 16;

  typedef enum logic [2:0] {
    FMT_U8 = 3'd0, FMT_S16 = 3'd1, FMT_S24 = 3'd2, FMT_S32 = 3'd3, FMT_F32 = 3'd4
  } fmt_t;

  typedef enum logic [2:0] {
    REG_FORMAT = 3'd0, REG_NARROW = 3'd1, REG_CHANS = 3'd2,
    REG_FRAMES = 3'd3, REG_VBEGIN = 3'd4, REG_VEND = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_RUN} ctl_state_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic [31:0] sample;
    logic        last_chan;
    logic        done;
  } item_t;

  function automatic logic [31:0] float_to_q31(input logic [31:0] b);
    logic [7:0]  e;
    logic [23:0] m;
    logic [31:0] mag;
    logic [31:0] res;
    e = b[30:23];
    m = {1'b1, b[22:0]};
    mag = 32'd0;
    if (e >= 8'd127) mag = 32'h8000_0000;
    else if (e >= 8'd119) mag = {8'd0, m} << (e - 8'd119);
    else if (e > 8'd87) mag = {8'd0, m >> (8'd119 - e)};
    if (e == 8'd255) res = (b[22:0] != 23'd0) ? 32'd0 :
                           (b[31] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    else if (e == 8'd0) res = 32'd0;
    else if (b[31]) res = mag[31] ? 32'h8000_0000 : (32'd0 - mag);
    else res = mag[31] ? 32'h7FFF_FFFF : mag;
    return res;
  endfunction

  function automatic logic [31:0] left_justify(input logic [2:0] f, input logic [31:0] b);
    logic [31:0] r;
    unique case (f)
      FMT_U8:  r = {b[7:0] ^ 8'h80, 24'd0};
      FMT_S16: r = {b[15:0], 16'd0};
      FMT_S24: r = {b[23:0], 8'd0};
      FMT_S32: r = b;
      FMT_F32: r = float_to_q31(b);
      default: r = 32'd0;
    endcase
    return r;
  endfunction
endpackage

// ===== design/pcmvr_div.sv =====
// serial signed divider for the ramp step, one quotient bit per cycle
module pcmvr_div import pcmvr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [12:0] divisor,
  output logic        busy,
  output logic [32:0] quotient
);
  logic [32:0] num;
  logic [13:0] rem;
  logic [5:0]  count;
  logic        neg;
  logic [12:0] den;
  logic [13:0] trial;
  logic [32:0] mag_in;

  assign mag_in = dividend[32] ? (33'd0 - dividend) : dividend;
  assign trial  = {rem[12:0], num[32]};
  assign quotient = neg ? (33'd0 - num) : num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 6'd33;
      num   <= mag_in;
      rem   <= '0;
      neg   <= dividend[32];
      den   <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        num <= {num[31:0], 1'b1};
      end else begin
        rem <= trial;
        num <= {num[31:0], 1'b0};
      end
      count <= count - 6'd1;
      if (count == 6'd1) busy <= 1'b0;
    end
  end
endmodule

// ===== design/pcmvr_front.sv =====
// front end: format conversion, position tracking and ramp control
module pcmvr_front import pcmvr_pkg::*; #(
  parameter int MaxFrames = DefMaxFrames,
  parameter int MaxChannels = DefMaxChannels
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] sample_bits,
  input  logic [2:0]  input_format,
  input  logic        output_narrow,
  input  logic [4:0]  channel_count,
  input  logic [12:0] frames_per_buffer,
  input  logic [15:0] volume_begin,
  input  logic [15:0] volume_end,
  input  logic        q_full,
  input  logic        q_empty,
  output logic        q_push,
  output item_t       q_item,
  output logic        vol_load,
  output logic [31:0] vol_init,
  output logic [32:0] step
);
  localparam int FW = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
  localparam int CW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;

  ctl_state_t state, state_next;
  logic [CW-1:0] chan_pos;
  logic [FW-1:0] frame_pos;
  logic [31:0]   held;
  logic          div_start, div_busy;
  logic [32:0]   quot;
  logic [16:0]   chans;
  logic [16:0]   frames;
  logic [12:0]   frames_div;
  logic          last_chan, done;
  logic [31:0]   lj;
  logic [33:0]   acc0;

  always_comb begin
    chans = {12'd0, channel_count};
    if (chans == 17'd0) chans = 17'd1;
    if (chans > 17'(MaxChannels)) chans = 17'(MaxChannels);
    frames = {4'd0, frames_per_buffer};
    if (frames == 17'd0) frames = 17'd1;
    if (frames > 17'(MaxFrames)) frames = 17'(MaxFrames);
    frames_div = frames[12:0];
  end

  pcmvr_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({1'b0, volume_end, 16'd0} - {1'b0, volume_begin, 16'd0}),
    .divisor(frames_div), .busy(div_busy), .quotient(quot)
  );

  assign last_chan = (17'(chan_pos) + 17'd1) >= chans;
  assign done = last_chan && ((17'(frame_pos) + 17'd1) >= frames);
  assign lj = left_justify(input_format, (state == ST_RUN) ? sample_bits : held);

  // ramp start: begin plus one step, clamped to unsigned 32 bits
  assign acc0 = {2'b00, volume_begin, 16'd0} + {quot[32], quot};

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    full       = 1'b1;
    q_push     = 1'b0;
    vol_load   = 1'b0;
    vol_init   = acc0[33] ? 32'd0 : (acc0[32] ? 32'hFFFF_FFFF : acc0[31:0]);
    q_item.sample    = output_narrow ? {{16{lj[31]}}, lj[31:16]} : lj;
    q_item.last_chan = last_chan;
    q_item.done      = done;
    unique case (state)
      ST_IDLE: begin
        full = 1'b0;
        if (push) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        // new ramp starts only after older items have picked up their volume
        if (!div_busy && !div_start && q_empty) begin
          q_push     = 1'b1;
          vol_load   = 1'b1;
          state_next = done ? ST_IDLE : ST_RUN;
        end
      end
      ST_RUN: begin
        full = q_full;
        if (push && !q_full) begin
          q_push = 1'b1;
          if (done) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chan_pos  <= '0;
      frame_pos <= '0;
      step      <= '0;
    end else begin
      state <= state_next;
      if (vol_load) step <= quot;
      if (q_push) begin
        if (done) begin
          chan_pos  <= '0;
          frame_pos <= '0;
        end else if (last_chan) begin
          chan_pos  <= '0;
          frame_pos <= frame_pos + 1'b1;
        end else begin
          chan_pos <= chan_pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && push) held <= sample_bits;
  end
endmodule

// ===== design/pcmvr_back.sv =====
// back end: item queue, volume accumulator, gain multiply and result register
module pcmvr_back import pcmvr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_push,
  input  item_t       q_item,
  output logic        q_full,
  output logic        q_empty,
  input  logic        output_narrow,
  input  logic        vol_load,
  input  logic [31:0] vol_init,
  input  logic [32:0] step,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_sample,
  output logic        buffer_done
);
  item_t       fifo [2];
  logic [0:0]  wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic [31:0] vacc;
  logic        st_valid;
  item_t       st_item;
  logic [15:0] st_vol;
  logic        st_narrow;
  logic signed [48:0] prod;
  logic signed [48:0] quo;
  logic        take;
  logic [33:0] acc_sum;

  // a new ramp is loaded only while the item queue is empty
  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign take    = (count != 2'd0) && (!st_valid || empty || pop);
  assign acc_sum = {2'b00, vacc} + {step[32], step};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      vacc   <= 32'h8000_0000;
    end else begin
      if (q_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) rd_ptr <= rd_ptr + 1'b1;
      count <= count + 2'(q_push) - 2'(take);
      if (vol_load) vacc <= vol_init;
      else if (take && fifo[rd_ptr].last_chan && !fifo[rd_ptr].done)
        vacc <= acc_sum[33] ? 32'd0 : (acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) fifo[wr_ptr] <= q_item;
  end

  // stage 1: item and volume; stage 2: product, scaling and saturation
  always_ff @(posedge clk) begin
    if (rst) st_valid <= 1'b0;
    else if (take) st_valid <= 1'b1;
    else if (st_valid && (empty || pop)) st_valid <= 1'b0;
    if (take) begin
      st_item   <= fifo[rd_ptr];
      st_vol    <= vacc[31:16];
      st_narrow <= output_narrow;
    end
  end

  assign prod = $signed({{17{st_item.sample[31]}}, st_item.sample}) * $signed({33'd0, st_vol});
  assign quo  = (prod + (prod[48] ? 49'sd32767 : 49'sd0)) >>> 15;

  always_ff @(posedge clk) begin
    if (rst) empty <= 1'b1;
    else if (st_valid && (empty || pop)) empty <= 1'b0;
    else if (pop) empty <= 1'b1;
    if (st_valid && (empty || pop)) begin
      buffer_done <= st_item.done;
      if (st_narrow) begin
        if (quo > 49'sd32767) out_sample <= 32'h0000_7FFF;
        else if (quo < -49'sd32768) out_sample <= 32'hFFFF_8000;
        else out_sample <= quo[31:0];
      end else begin
        if (quo > 49'sd2147483647) out_sample <= 32'h7FFF_FFFF;
        else if (quo < -49'sd2147483648) out_sample <= 32'h8000_0000;
        else out_sample <= quo[31:0];
      end
    end
  end
endmodule

// ===== design/pcm_to_fixed_volume_ramp_core.sv =====
// top level: pcm conversion with linear volume ramp
// channel  | handshake          | payload
// input    | push / full        | sample_bits
// result   | empty / pop        | out_sample, buffer_done
// config   | apb write, pready=1| pwdata at paddr 4*index
// one sample per cycle inside a buffer while the item queue is not full; the
// first sample of a buffer enters the queue when the serial step divider (one
// quotient bit a cycle) is done and the queue is empty; rst is synchronous
// queued items pass a stage register and then the result register
// full is high in ST_DIV (divide, queue drain) or when the two-entry queue fills
module pcm_to_fixed_volume_ramp_core import pcmvr_pkg::*; #(
  parameter int MaxFrames = DefMaxFrames,
  parameter int MaxChannels = DefMaxChannels
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] sample_bits,
  output logic        empty,
  input  logic        pop,
  output logic signed [31:0] out_sample,
  output logic        buffer_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [2:0]  input_format;
  logic        output_narrow;
  logic [4:0]  channel_count;
  logic [12:0] frames_per_buffer;
  logic [15:0] volume_begin, volume_end;
  logic        q_full, q_empty, q_push, vol_load;
  item_t       q_item;
  logic [31:0] vol_init;
  logic [32:0] step;
  logic [31:0] out_raw;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      input_format      <= 3'd1;
      output_narrow     <= 1'b0;
      channel_count     <= 5'd2;
      frames_per_buffer <= 13'd1024;
      volume_begin      <= 16'd32768;
      volume_end        <= 16'd32768;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_FORMAT:  input_format      <= pwdata[2:0];
        REG_NARROW:  output_narrow     <= pwdata[0];
        REG_CHANS:   channel_count     <= pwdata[4:0];
        REG_FRAMES:  frames_per_buffer <= pwdata[12:0];
        REG_VBEGIN:  volume_begin      <= pwdata[15:0];
        REG_VEND:    volume_end        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FORMAT: prdata = {29'd0, input_format};
      REG_NARROW: prdata = {31'd0, output_narrow};
      REG_CHANS:  prdata = {27'd0, channel_count};
      REG_FRAMES: prdata = {19'd0, frames_per_buffer};
      REG_VBEGIN: prdata = {16'd0, volume_begin};
      REG_VEND:   prdata = {16'd0, volume_end};
      default:    prdata = 32'd0;
    endcase
  end

  pcmvr_front #(.MaxFrames(MaxFrames), .MaxChannels(MaxChannels)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .sample_bits(sample_bits),
    .input_format(input_format), .output_narrow(output_narrow),
    .channel_count(channel_count), .frames_per_buffer(frames_per_buffer),
    .volume_begin(volume_begin), .volume_end(volume_end),
    .q_full(q_full), .q_empty(q_empty), .q_push(q_push), .q_item(q_item),
    .vol_load(vol_load), .vol_init(vol_init), .step(step)
  );

  pcmvr_back u_back (
    .clk(clk), .rst(rst), .q_push(q_push), .q_item(q_item), .q_full(q_full),
    .q_empty(q_empty),
    .output_narrow(output_narrow), .vol_load(vol_load), .vol_init(vol_init),
    .step(step), .empty(empty), .pop(pop), .out_sample(out_raw),
    .buffer_done(buffer_done)
  );

  assign out_sample = out_raw;
endmodule

// ===== design/pcmvr_checker.sv =====
// port-level checks for the pcm volume ramp core
module pcmvr_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] out_sample,
  input logic        buffer_done,
  input logic        pready
);
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_sample) && $stable(buffer_done))
    else $error("result changed while stalled");
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result after reset");
  a_reset_full: assert property (@(posedge clk) rst |=> !full)
    else $error("full after reset");
endmodule

bind pcm_to_fixed_volume_ramp_core pcmvr_checker u_chk (
  .clk(clk), .rst(rst), .full(full), .empty(empty), .pop(pop),
  .out_sample(out_sample), .buffer_done(buffer_done), .pready(pready)
);
